@@ sv/reversible_deque_macros.svh @@
// Assertion helpers shared by the deque RTL.
// Checks compile away when SYNTHESIS is defined.
`ifndef REVERSIBLE_DEQUE_MACROS_SVH
`define REVERSIBLE_DEQUE_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising edge, switched off while reset is high
`define RDQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("reversible_deque: check failed");
// Check on every rising edge, reset included
`define RDQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("reversible_deque: check failed");
`else
`define RDQ_ASSERT(lbl, clk, rst, prop)
`define RDQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/rdq_pkg.sv @@
package rdq_pkg;

   // Default geometry of the ring
   localparam int DepthDefault     = 16;
   localparam int DataWidthDefault = 32;

   // Fixed widths of the channel fields
   localparam int FieldWidth  = 32;
   localparam int FuncWidth   = 3;
   localparam int StatusWidth = 2;

   // Operation codes; the remaining codes do nothing
   typedef enum logic [FuncWidth-1:0] {
      FuncPushFront = 3'd0,
      FuncPushBack  = 3'd1,
      FuncPopFront  = 3'd2,
      FuncPopBack   = 3'd3,
      FuncToggle    = 3'd4
   } func_type;

   // Result status codes
   typedef enum logic [StatusWidth-1:0] {
      StatusOk    = 2'd0,
      StatusFull  = 2'd1,
      StatusEmpty = 2'd2
   } status_type;

   // Per-result flags handed from the controller to the top level
   typedef struct packed {
      logic       pop_valid;
      status_type status;
      logic       reversed;
      logic       is_empty;
   } rsp_flags_type;

endpackage

@@ sv/rdq_ram.sv @@
module rdq_ram #(
   parameter int WIDTH = rdq_pkg::DataWidthDefault,
   parameter int DEPTH = rdq_pkg::DepthDefault
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write one word; read two words, old data on a clash
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ sv/rdq_ctrl.sv @@
`include "reversible_deque_macros.svh"

module rdq_ctrl #(
   parameter int DEPTH      = rdq_pkg::DepthDefault,
   parameter int DATA_WIDTH = rdq_pkg::DataWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [rdq_pkg::FuncWidth-1:0] func,
   input  logic [DATA_WIDTH-1:0]         word,
   input  logic [DATA_WIDTH-1:0]         rd_a_data,
   input  logic [DATA_WIDTH-1:0]         rd_b_data,
   output logic                          wr_en,
   output logic [$clog2(DEPTH)-1:0]      wr_addr,
   output logic [$clog2(DEPTH)-1:0]      rd_a_addr,
   output logic [$clog2(DEPTH)-1:0]      rd_b_addr,
   output logic [DATA_WIDTH-1:0]         pop_word,
   output logic [DATA_WIDTH-1:0]         front_word,
   output logic [DATA_WIDTH-1:0]         back_word,
   output logic [$clog2(DEPTH+1)-1:0]    entry_count,
   output rdq_pkg::rsp_flags_type        flags
);

   localparam int PtrWidth = $clog2(DEPTH);
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [PtrWidth:0]   PtrWrap = (PtrWidth + 1)'(DEPTH);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

   logic [PtrWidth-1:0]   head_ff, head_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  rev_ff, rev_in;
   logic                  byp_a_ff, byp_a_in;
   logic                  byp_b_ff, byp_b_in;
   logic [DATA_WIDTH-1:0] byp_data_ff;
   logic [DATA_WIDTH-1:0] pop_word_ff, pop_word_in;
   rdq_pkg::rsp_flags_type flags_ff, flags_in;

   logic                  is_push, is_pop, at_front, full, empty;
   logic [PtrWidth-1:0]   head_dec, head_inc;
   logic [DATA_WIDTH-1:0] phys_front, phys_back;
   logic [PtrWidth-1:0]   wr_addr_c;
   logic                  wr_en_c;
   logic                  push_full, pop_any;

   // Add two ring offsets, wrapping once at the ring size
   function automatic logic [PtrWidth-1:0] ptr_add(input logic [PtrWidth-1:0] a,
                                                   input logic [PtrWidth-1:0] b);
      logic [PtrWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= PtrWrap) begin
         s = s - PtrWrap;
      end
      return s[PtrWidth-1:0];
   endfunction

   // Words at both physical ends of the current state
   assign phys_front = byp_a_ff ? byp_data_ff : rd_a_data;
   assign phys_back  = byp_b_ff ? byp_data_ff : rd_b_data;

   assign head_dec = (head_ff == '0) ? PtrLast : head_ff - 1'b1;
   assign head_inc = (head_ff == PtrLast) ? '0 : head_ff + 1'b1;
   assign full     = (count_ff == CntFull);
   assign empty    = (count_ff == '0);

   assign is_push = (func == rdq_pkg::FuncPushFront) || (func == rdq_pkg::FuncPushBack);
   assign is_pop  = (func == rdq_pkg::FuncPopFront) || (func == rdq_pkg::FuncPopBack);

   // Work out which physical end the operation touches
   always_comb begin
      if (is_push) begin
         at_front = (func == rdq_pkg::FuncPushFront) == !rev_ff;
      end else begin
         at_front = (func == rdq_pkg::FuncPopFront) == !rev_ff;
      end
   end

   // Next state and result of one operation
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      rev_in      = rev_ff;
      wr_en_c     = 1'b0;
      wr_addr_c   = ptr_add(head_ff, PtrWidth'(count_ff));
      pop_word_in = '0;
      flags_in    = '{pop_valid: 1'b0, status: rdq_pkg::StatusOk,
                      reversed: rev_ff, is_empty: 1'b0};
      case (func)
         rdq_pkg::FuncPushFront, rdq_pkg::FuncPushBack: begin
            if (full) begin
               flags_in.status = rdq_pkg::StatusFull;
            end else begin
               wr_en_c  = 1'b1;
               count_in = count_ff + 1'b1;
               if (at_front) begin
                  head_in   = head_dec;
                  wr_addr_c = head_dec;
               end
            end
         end
         rdq_pkg::FuncPopFront, rdq_pkg::FuncPopBack: begin
            if (empty) begin
               flags_in.status = rdq_pkg::StatusEmpty;
            end else begin
               flags_in.pop_valid = 1'b1;
               count_in           = count_ff - 1'b1;
               if (at_front) begin
                  pop_word_in = phys_front;
                  head_in     = head_inc;
               end else begin
                  pop_word_in = phys_back;
               end
            end
         end
         rdq_pkg::FuncToggle: begin
            rev_in = ~rev_ff;
         end
         default: begin
         end
      endcase
      flags_in.reversed = rev_in;
      flags_in.is_empty = (count_in == '0);
   end

   // Fetch both ends of the new state; forward a word written to the same entry
   assign rd_a_addr = head_in;
   assign rd_b_addr = ptr_add(head_in, PtrWidth'(count_in - 1'b1));
   assign byp_a_in  = wr_en_c && (wr_addr_c == rd_a_addr);
   assign byp_b_in  = wr_en_c && (wr_addr_c == rd_b_addr);
   assign wr_en     = accept && wr_en_c;
   assign wr_addr   = wr_addr_c;

   // Hold state and result until the next accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
         byp_a_ff <= 1'b0;
         byp_b_ff <= 1'b0;
         flags_ff <= '{pop_valid: 1'b0, status: rdq_pkg::StatusOk,
                       reversed: 1'b0, is_empty: 1'b1};
      end else if (accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
         byp_a_ff <= byp_a_in;
         byp_b_ff <= byp_b_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byp_data_ff <= word;
         pop_word_ff <= pop_word_in;
      end
   end

   // Present logical ends of the state after the step
   assign front_word  = empty ? '0 : (rev_ff ? phys_back : phys_front);
   assign back_word   = empty ? '0 : (rev_ff ? phys_front : phys_back);
   assign pop_word    = pop_word_ff;
   assign entry_count = count_ff;
   assign flags       = flags_ff;

   // Flag the accepted operations that the checks look at
   assign push_full = accept && is_push && full;
   assign pop_any   = accept && is_pop && !empty;

   `RDQ_ASSERT(a_count_bound, clock, reset, count_ff <= CntFull)
   `RDQ_ASSERT(a_full_hold, clock, reset, push_full |=> $stable(count_ff) && $stable(head_ff))
   `RDQ_ASSERT(a_pop_decrements, clock, reset, pop_any |=> count_ff + 1'b1 == $past(count_ff))
   `RDQ_ASSERT(a_bypass_needs_write, clock, reset, accept && !wr_en_c |=> !byp_a_ff && !byp_b_ff)
   `RDQ_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> count_ff == '0 && head_ff == '0 && !rev_ff)

endmodule

@@ sv/reversible_deque.sv @@
// Bounded double-ended queue of DEPTH words kept in a ring memory. Each request
// word carries one operation (push front, push back, pop front, pop back or
// toggle reverse) and yields exactly one response word with the popped word, a
// status (ok, push dropped because full, pop on empty) and the queue's front,
// back, count and reverse mode after the operation. One request is taken per
// clock cycle: the ring pointers and count update in the cycle the request is
// taken, and both ends of the new state are read from the two-read-port ring
// memory in that same cycle, so the response is ready in the next cycle. A
// response that is not taken holds the request side off until it is. No
// clearing pass is needed after reset: only entries that a push wrote are shown.
`include "reversible_deque_macros.svh"

module reversible_deque #(
   parameter int DEPTH      = rdq_pkg::DepthDefault,
   parameter int DATA_WIDTH = rdq_pkg::DataWidthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rdq_pkg::FuncWidth-1:0]   req_func,
   input  logic [rdq_pkg::FieldWidth-1:0]  req_push_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rdq_pkg::FieldWidth-1:0]  rsp_pop_data,
   output logic                            rsp_pop_valid,
   output logic [rdq_pkg::StatusWidth-1:0] rsp_status,
   output logic [rdq_pkg::FieldWidth-1:0]  rsp_front_word,
   output logic [rdq_pkg::FieldWidth-1:0]  rsp_back_word,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_entry_count,
   output logic                            rsp_is_empty,
   output logic                            rsp_reversed
);

   localparam int PtrWidth = $clog2(DEPTH);
   localparam int FW       = rdq_pkg::FieldWidth;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic [DATA_WIDTH-1:0]  word;
   logic                   wr_en;
   logic [PtrWidth-1:0]    wr_addr, rd_a_addr, rd_b_addr;
   logic [DATA_WIDTH-1:0]  rd_a_data, rd_b_data;
   logic [DATA_WIDTH-1:0]  pop_word, front_word, back_word;
   rdq_pkg::rsp_flags_type flags;

   // Take a request word when the response slot is free or being emptied
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Fit the channel fields to the stored word width
   generate
      if (DATA_WIDTH == FW) begin : g_fit_equal
         assign word           = req_push_data;
         assign rsp_pop_data   = pop_word;
         assign rsp_front_word = front_word;
         assign rsp_back_word  = back_word;
      end else if (DATA_WIDTH > FW) begin : g_fit_wide
         assign word           = {{(DATA_WIDTH - FW){1'b0}}, req_push_data};
         assign rsp_pop_data   = pop_word[FW-1:0];
         assign rsp_front_word = front_word[FW-1:0];
         assign rsp_back_word  = back_word[FW-1:0];
      end else begin : g_fit_narrow
         assign word           = req_push_data[DATA_WIDTH-1:0];
         assign rsp_pop_data   = {{(FW - DATA_WIDTH){1'b0}}, pop_word};
         assign rsp_front_word = {{(FW - DATA_WIDTH){1'b0}}, front_word};
         assign rsp_back_word  = {{(FW - DATA_WIDTH){1'b0}}, back_word};
      end
   endgenerate

   rdq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (req_func),
      .word        (word),
      .rd_a_data   (rd_a_data),
      .rd_b_data   (rd_b_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_a_addr   (rd_a_addr),
      .rd_b_addr   (rd_b_addr),
      .pop_word    (pop_word),
      .front_word  (front_word),
      .back_word   (back_word),
      .entry_count (rsp_entry_count),
      .flags       (flags)
   );

   rdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (word),
      .rd_en     (accept),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // Drive the response word
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_valid = flags.pop_valid;
   assign rsp_status    = flags.status;
   assign rsp_is_empty  = flags.is_empty;
   assign rsp_reversed  = flags.reversed;

   `RDQ_ASSERT(a_accept_gives_rsp, clock, reset, accept |=> rsp_valid_ff)
   `RDQ_ASSERT(a_rsp_holds, clock, reset, rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
   `RDQ_ASSERT(a_stall_on_full, clock, reset, rsp_valid_ff && !rsp_ready |-> !req_ready)

endmodule
